### rtl/dq_pkg.sv
package dq_pkg;

	localparam int DQ_DEPTH       = 16;
	localparam int DQ_ENTRY_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} dq_op_t;

	// One-hot: at most one is set, and only for an accepted word that succeeds.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} dq_ctrl_t;

endpackage

### rtl/dq_cell.sv
module dq_cell import dq_pkg::*; #(
	parameter int ENTRY_WIDTH = DQ_ENTRY_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dq_ctrl_t               ctrl,
	input  logic [ENTRY_WIDTH-1:0] push_value,
	input  logic                   left_occ,
	input  logic [ENTRY_WIDTH-1:0] left_data,
	input  logic                   right_occ,
	input  logic [ENTRY_WIDTH-1:0] right_data,
	output logic                   occ,
	output logic [ENTRY_WIDTH-1:0] data,
	output logic [ENTRY_WIDTH-1:0] tail_data
);

	logic                   occ_q;
	logic [ENTRY_WIDTH-1:0] data_q;
	logic                   is_tail;

	// this cell holds the back entry
	assign is_tail = occ_q & ~right_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			priority if (ctrl.push_front) begin
				occ_q <= left_occ;
			end else if (ctrl.push_back) begin
				if (!occ_q && left_occ) begin
					occ_q <= 1'b1;
				end
			end else if (ctrl.pop_front) begin
				occ_q <= right_occ;
			end else if (ctrl.pop_back) begin
				if (is_tail) begin
					occ_q <= 1'b0;
				end
			end else begin
				occ_q <= occ_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.push_front) begin
			data_q <= left_data;
		end else if (ctrl.push_back) begin
			if (!occ_q && left_occ) begin
				data_q <= push_value;
			end
		end else if (ctrl.pop_front) begin
			data_q <= right_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign occ       = occ_q;
	assign data      = data_q;
	assign tail_data = is_tail ? data_q : '0;

endmodule

### rtl/double_ended_queue.sv
// Fixed-capacity double-ended queue built as a row of shifting cells.
// The result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready is held high; every cell
// updates in the same cycle, and the pop-back word comes from the one-hot tail mux.
// Reset: entry count and occupancy cleared, capacity set to DEPTH, output empty;
// cell data is not reset.
module double_ended_queue import dq_pkg::*; #(
	parameter  int DEPTH       = DQ_DEPTH,
	parameter  int ENTRY_WIDTH = DQ_ENTRY_WIDTH,
	localparam int CNT_W       = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration: capacity register
	input  logic                   cfg_wen,
	input  logic [CNT_W-1:0]       cfg_wdata,
	// input words
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [ENTRY_WIDTH-1:0] push_value,
	// result words
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   ok,
	output logic [ENTRY_WIDTH-1:0] pop_value,
	output logic [CNT_W-1:0]       count_after,
	output logic                   is_full,
	output logic                   is_empty
);

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	logic [CNT_W-1:0] cap_q;     // capacity as written
	logic [CNT_W-1:0] count_q;   // entries held
	logic [CNT_W-1:0] cap_eff;   // capacity saturated to DEPTH
	logic [CNT_W-1:0] count_nxt;

	// output register
	logic                   out_valid_q;
	logic                   ok_q;
	logic [ENTRY_WIDTH-1:0] pop_value_q;
	logic [CNT_W-1:0]       count_after_q;
	logic                   is_full_q;
	logic                   is_empty_q;

	logic     in_acc;
	dq_op_t   op_c;
	logic     push_ok;
	logic     pop_ok;
	logic     done;
	dq_ctrl_t ctrl;

	// cell row wiring
	logic [DEPTH-1:0]       occ;
	logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];
	logic [ENTRY_WIDTH-1:0] tail_data [DEPTH];
	logic [ENTRY_WIDTH-1:0] back_value;
	logic [ENTRY_WIDTH-1:0] popped;

	// The output register frees up in the same cycle it is taken, so a new
	// word goes in while the previous result drains.
	assign in_ready = ~out_valid_q | out_ready;
	assign in_acc   = in_valid & in_ready;
	assign op_c     = dq_op_t'(op);

	assign cap_eff = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	// cap_eff never exceeds DEPTH, so this also keeps the row from overflowing
	assign push_ok = count_q < cap_eff;
	assign pop_ok  = count_q != '0;

	always_comb begin
		ctrl      = '0;
		done      = 1'b0;
		count_nxt = count_q;
		unique case (op_c)
			OP_PUSH_FRONT: begin
				done            = push_ok;
				ctrl.push_front = in_acc & push_ok;
				if (push_ok) count_nxt = count_q + 1'b1;
			end
			OP_PUSH_BACK: begin
				done           = push_ok;
				ctrl.push_back = in_acc & push_ok;
				if (push_ok) count_nxt = count_q + 1'b1;
			end
			OP_POP_FRONT: begin
				done           = pop_ok;
				ctrl.pop_front = in_acc & pop_ok;
				if (pop_ok) count_nxt = count_q - 1'b1;
			end
			OP_POP_BACK: begin
				done          = pop_ok;
				ctrl.pop_back = in_acc & pop_ok;
				if (pop_ok) count_nxt = count_q - 1'b1;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Cell row: cell 0 is the front. Occupancy is a thermometer code
	// of the count; push-front and pop-front shift the whole row.
	// ---------------------------------------------------------------
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   l_occ;
		logic [ENTRY_WIDTH-1:0] l_data;
		logic                   r_occ;
		logic [ENTRY_WIDTH-1:0] r_data;

		if (i == 0) begin : g_first
			// a push at the front enters here
			assign l_occ  = 1'b1;
			assign l_data = push_value;
		end else begin : g_mid
			assign l_occ  = occ[i-1];
			assign l_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_occ  = 1'b0;
			assign r_data = '0;
		end else begin : g_inner
			assign r_occ  = occ[i+1];
			assign r_data = cell_data[i+1];
		end

		dq_cell #(
			.ENTRY_WIDTH(ENTRY_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.push_value(push_value),
			.left_occ  (l_occ),
			.left_data (l_data),
			.right_occ (r_occ),
			.right_data(r_data),
			.occ       (occ[i]),
			.data      (cell_data[i]),
			.tail_data (tail_data[i])
		);
	end

	// Only the tail cell drives a nonzero value, so an OR picks the back.
	always_comb begin
		back_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_value = back_value | tail_data[i];
		end
	end

	always_comb begin
		popped = '0;
		if (done && op_c == OP_POP_FRONT) begin
			popped = cell_data[0];
		end else if (done && op_c == OP_POP_BACK) begin
			popped = back_value;
		end
	end

	// ---------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CNT_W'(DEPTH);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			if (in_acc) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_q          <= done;
			pop_value_q   <= popped;
			count_after_q <= count_nxt;
			is_full_q     <= count_nxt >= cap_eff;
			is_empty_q    <= count_nxt == '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign pop_value   = pop_value_q;
	assign count_after = count_after_q;
	assign is_full     = is_full_q;
	assign is_empty    = is_empty_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ) == int'(count_q))
		else $error("cell occupancy does not match entry count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !done) |=> $stable(count_q))
		else $error("failed operation changed the count");

	a_fail_pops_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (pop_value_q == '0))
		else $error("failed operation returned a nonzero value");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (out_valid_q && count_after_q == count_q))
		else $error("result word missing or count mismatch");

endmodule
